// ===== design/dwse_pkg.sv =====
`default_nettype none
package dwse_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned WgtW     = 20;
  localparam int unsigned SpdW     = 24;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned LimW     = 23;
  localparam int unsigned GainW    = 32;
  localparam int unsigned DistW    = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_SCALE    = 2'd0,
    CFG_RIGHT_SCALE   = 2'd1,
    CFG_SPEED_LIMIT   = 2'd2,
    CFG_DISTANCE_GAIN = 2'd3
  } cfg_idx_e;

  localparam logic [ScaleW-1:0] ScaleRst = 24'd2621;
  localparam logic [LimW-1:0]   LimitRst = 23'd524288;
  localparam logic [GainW-1:0]  GainRst  = 32'd1717987;

  // ceil(2^32 / 10), exact floor(m / 10) for m below 2^30
  localparam logic [28:0] Recip10 = 29'd429496730;

  // filter weights, 0.15 and 0.85 in Q0.16
  localparam logic signed [14:0] KOld = 15'sd9830;
  localparam logic signed [17:0] KNew = 18'sd55706;

  // scaled count cap, far beyond anything that clears the speed clamp
  localparam logic [26:0] XCap = 27'h7FFFFFF;

  localparam logic signed [29:0] SpdMin = -30'sd8388608;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPLIT,
    ST_FRAC,
    ST_FILT,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic div;
    logic split;
    logic frac;
    logic filt;
    logic upd;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic signed [SpdW-1:0]  left_speed_out;
    logic signed [SpdW-1:0]  right_speed_out;
    logic signed [SpdW-1:0]  mean_speed;
    logic signed [WgtW-1:0]  left_weighted;
    logic signed [WgtW-1:0]  right_weighted;
    logic signed [DistW-1:0] distance_out;
  } result_t;

endpackage
`default_nettype wire

// ===== design/dwse_in_if.sv =====
`default_nettype none
interface dwse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dwse_pkg::CntW-1:0]     left_delta;
  logic signed [dwse_pkg::CntW-1:0]     right_raw_count;

  modport source (output valid, output left_delta, output right_raw_count, input ready);
  modport sink (input valid, input left_delta, input right_raw_count, output ready);
endinterface
`default_nettype wire

// ===== design/dwse_out_if.sv =====
`default_nettype none
interface dwse_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dwse_pkg::SpdW-1:0]     left_speed_out;
  logic signed [dwse_pkg::SpdW-1:0]     right_speed_out;
  logic signed [dwse_pkg::SpdW-1:0]     mean_speed;
  logic signed [dwse_pkg::WgtW-1:0]     left_weighted;
  logic signed [dwse_pkg::WgtW-1:0]     right_weighted;
  logic signed [dwse_pkg::DistW-1:0]    distance_out;

  modport source (
    output valid, output left_speed_out, output right_speed_out, output mean_speed,
    output left_weighted, output right_weighted, output distance_out, input ready
  );
  modport sink (
    input valid, input left_speed_out, input right_speed_out, input mean_speed,
    input left_weighted, input right_weighted, input distance_out, output ready
  );
endinterface
`default_nettype wire

// ===== design/dwse_lane.sv =====
`default_nettype none
module dwse_lane (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  dwse_pkg::ctrl_t                ctrl_i,
  input  wire  logic signed [dwse_pkg::CntW-1:0] count_i,
  input  wire  logic [dwse_pkg::ScaleW-1:0]    scale_i,
  input  wire  logic [dwse_pkg::LimW-1:0]      limit_i,
  output logic signed [dwse_pkg::WgtW-1:0]     weight_o,
  output logic signed [dwse_pkg::SpdW-1:0]     speed_o
);

  logic signed [dwse_pkg::CntW-1:0] hist_q [3];
  logic signed [dwse_pkg::SpdW-1:0] speed_q, speed_d;

  logic signed [dwse_pkg::WgtW-1:0] w_q, w_d;
  logic [18:0]                      wm_q, wm_d;
  logic                             neg_q;
  logic [15:0]                      a_q, a_d;
  logic [27:0]                      m2_q, m2_d;
  logic [39:0]                      as_q, as_d;
  logic [23:0]                      q2_q, q2_d;
  logic signed [37:0]               pv_q, pv_d;
  logic signed [44:0]               px_q, px_d;

  logic signed [dwse_pkg::WgtW-1:0] c0e, h0e, h1e, h2e;
  logic [47:0]                      diva_p;
  logic [18:0]                      ten_a;
  logic [3:0]                       b;
  logic [56:0]                      frac_p;
  logic [40:0]                      xm;
  logic [26:0]                      xc;
  logic signed [27:0]               x;
  logic signed [45:0]               s;
  logic signed [29:0]               r;
  logic signed [29:0]               lim;

  // weighted count 4c0 + 3c1 + 2c2 + c3
  always_comb begin
    c0e  = 20'(count_i);
    h0e  = 20'(hist_q[0]);
    h1e  = 20'(hist_q[1]);
    h2e  = 20'(hist_q[2]);
    w_d  = (c0e <<< 2) + (h0e <<< 1) + h0e + (h1e <<< 1) + h2e;
    wm_d = w_d[dwse_pkg::WgtW-1] ? 19'(-w_d) : 19'(w_d);
  end

  // |w| = 10a + b, then |w|*scale/10 = a*scale + (b*scale)/10
  always_comb begin
    diva_p = 48'(wm_q) * 48'(dwse_pkg::Recip10);
    a_d    = diva_p[47:32];
    ten_a  = 19'({a_q, 3'b000}) + 19'({a_q, 1'b0});
    b      = 4'(wm_q - ten_a);
    m2_d   = 28'(b) * 28'(scale_i);
    as_d   = 40'(a_q) * 40'(scale_i);
    frac_p = 57'(m2_q) * 57'(dwse_pkg::Recip10);
    q2_d   = frac_p[55:32];
  end

  always_comb begin
    xm   = 41'(as_q) + 41'(q2_q);
    xc   = (xm > 41'(dwse_pkg::XCap)) ? dwse_pkg::XCap : xm[26:0];
    x    = neg_q ? -$signed({1'b0, xc}) : $signed({1'b0, xc});
    pv_d = speed_q * dwse_pkg::KOld;
    px_d = x * dwse_pkg::KNew;
  end

  always_comb begin
    s   = 46'(pv_q) + 46'(px_q);
    r   = 30'(s >>> 16);
    lim = $signed(30'(limit_i));
    if (r > lim) begin
      speed_d = 24'(lim);
    end else if (r < dwse_pkg::SpdMin) begin
      speed_d = 24'(dwse_pkg::SpdMin);
    end else begin
      speed_d = r[dwse_pkg::SpdW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      speed_q   <= '0;
    end else begin
      if (ctrl_i.start) begin
        hist_q[2] <= hist_q[1];
        hist_q[1] <= hist_q[0];
        hist_q[0] <= count_i;
      end
      if (ctrl_i.upd) begin
        speed_q <= speed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      w_q   <= w_d;
      wm_q  <= wm_d;
      neg_q <= w_d[dwse_pkg::WgtW-1];
    end
    if (ctrl_i.div) begin
      a_q <= a_d;
    end
    if (ctrl_i.split) begin
      m2_q <= m2_d;
      as_q <= as_d;
    end
    if (ctrl_i.frac) begin
      q2_q <= q2_d;
    end
    if (ctrl_i.filt) begin
      pv_q <= pv_d;
      px_q <= px_d;
    end
  end

  assign weight_o = w_q;
  assign speed_o  = speed_q;

endmodule
`default_nettype wire

// ===== design/dwse_merge.sv =====
`default_nettype none
module dwse_merge (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  dwse_pkg::ctrl_t                 ctrl_i,
  input  wire  logic signed [dwse_pkg::WgtW-1:0] left_w_i,
  input  wire  logic signed [dwse_pkg::WgtW-1:0] right_w_i,
  input  wire  logic signed [dwse_pkg::SpdW-1:0] left_speed_i,
  input  wire  logic signed [dwse_pkg::SpdW-1:0] right_speed_i,
  input  wire  logic [dwse_pkg::GainW-1:0]      gain_i,
  output dwse_pkg::result_t                     res_o
);

  logic signed [dwse_pkg::WgtW:0]    wsum;
  logic signed [52:0]                add_q, add_d;
  logic signed [dwse_pkg::DistW:0]   sum;
  logic signed [dwse_pkg::DistW-1:0] dist_q, dist_d;
  logic signed [dwse_pkg::SpdW:0]    spd_sum;
  dwse_pkg::result_t                 res_q, res_d;

  always_comb begin
    wsum  = 21'(left_w_i) + 21'(right_w_i);
    add_d = wsum * $signed({1'b0, gain_i});
  end

  // saturating accumulate: overflow when the two top bits disagree
  always_comb begin
    sum = 65'(dist_q) + 65'(add_q);
    if (sum[dwse_pkg::DistW] != sum[dwse_pkg::DistW-1]) begin
      dist_d = sum[dwse_pkg::DistW] ? {1'b1, {(dwse_pkg::DistW-1){1'b0}}}
                                     : {1'b0, {(dwse_pkg::DistW-1){1'b1}}};
    end else begin
      dist_d = sum[dwse_pkg::DistW-1:0];
    end
  end

  always_comb begin
    spd_sum               = 25'(left_speed_i) + 25'(right_speed_i);
    res_d.left_speed_out  = left_speed_i;
    res_d.right_speed_out = right_speed_i;
    res_d.mean_speed      = spd_sum[dwse_pkg::SpdW:1];
    res_d.left_weighted   = left_w_i;
    res_d.right_weighted  = right_w_i;
    res_d.distance_out    = dist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (ctrl_i.split) begin
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div) begin
      add_q <= add_d;
    end
    if (ctrl_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== design/dual_wheel_speed_estimator.sv =====
// Dual wheel speed estimator.
// in_i carries one word per control tick: the left and the raw right encoder
// count deltas. out_o returns one word per input word: both filtered wheel
// speeds (Q8.16), their mean, both weighted count sums and the saturating
// Q32.32 distance. The cfg port writes scale, speed limit and distance gain
// registers; write them only while no word is in flight.
// Two identical lanes, one per wheel, run the history, the divide by ten and
// the speed filter side by side; a merge stage forms the mean and distance.
// An input word is taken only when the sequencer is idle, and its result is
// loaded into the output register in the output step and is offered to the
// receiver once loaded. After the accept cycle the sequencer walks six steps
// (divide, split, fraction, filter products, update, output), so a new word
// is accepted only once the sequencer is back in idle.
// The output register lets the next word be accepted while a result waits;
// if the receiver stalls, the sequencer holds in its output step until the
// waiting word is taken.
// Reset clears the histories, speeds and distance and loads the default
// register values; no clearing pass is needed.
`default_nettype none
module dual_wheel_speed_estimator (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  dwse_in_if.sink                              in_i,
  dwse_out_if.source                           out_o,
  input  wire                                  cfg_we_i,
  input  wire  logic [dwse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  logic [dwse_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [dwse_pkg::ScaleW-1:0] lscale_q, rscale_q;
  logic [dwse_pkg::LimW-1:0]   limit_q;
  logic [dwse_pkg::GainW-1:0]  gain_q;

  dwse_pkg::state_e            state_q, state_d;
  dwse_pkg::ctrl_t             ctrl;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic signed [dwse_pkg::CntW-1:0] right_neg;

  logic signed [dwse_pkg::WgtW-1:0] wl, wr;
  logic signed [dwse_pkg::SpdW-1:0] sl, sr;
  dwse_pkg::result_t                res;

  assign in_i.ready = (state_q == dwse_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // negate right count, most negative value saturates
  assign right_neg = (in_i.right_raw_count == {1'b1, {(dwse_pkg::CntW-1){1'b0}}})
                     ? {1'b0, {(dwse_pkg::CntW-1){1'b1}}} : -in_i.right_raw_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lscale_q <= dwse_pkg::ScaleRst;
      rscale_q <= dwse_pkg::ScaleRst;
      limit_q  <= dwse_pkg::LimitRst;
      gain_q   <= dwse_pkg::GainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dwse_pkg::CFG_LEFT_SCALE:    lscale_q <= cfg_data_i[dwse_pkg::ScaleW-1:0];
        dwse_pkg::CFG_RIGHT_SCALE:   rscale_q <= cfg_data_i[dwse_pkg::ScaleW-1:0];
        dwse_pkg::CFG_SPEED_LIMIT:   limit_q  <= cfg_data_i[dwse_pkg::LimW-1:0];
        dwse_pkg::CFG_DISTANCE_GAIN: gain_q   <= cfg_data_i[dwse_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dwse_pkg::ST_IDLE:  if (accept) state_d = dwse_pkg::ST_DIV;
      dwse_pkg::ST_DIV:   state_d = dwse_pkg::ST_SPLIT;
      dwse_pkg::ST_SPLIT: state_d = dwse_pkg::ST_FRAC;
      dwse_pkg::ST_FRAC:  state_d = dwse_pkg::ST_FILT;
      dwse_pkg::ST_FILT:  state_d = dwse_pkg::ST_UPD;
      dwse_pkg::ST_UPD:   state_d = dwse_pkg::ST_OUT;
      dwse_pkg::ST_OUT:   if (!out_valid_q || out_o.ready) state_d = dwse_pkg::ST_IDLE;
      default:            state_d = dwse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      dwse_pkg::ST_IDLE:  ctrl.start    = accept;
      dwse_pkg::ST_DIV:   ctrl.div      = 1'b1;
      dwse_pkg::ST_SPLIT: ctrl.split    = 1'b1;
      dwse_pkg::ST_FRAC:  ctrl.frac     = 1'b1;
      dwse_pkg::ST_FILT:  ctrl.filt     = 1'b1;
      dwse_pkg::ST_UPD:   ctrl.upd      = 1'b1;
      dwse_pkg::ST_OUT:   ctrl.out_load = !out_valid_q || out_o.ready;
      default:            ctrl = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dwse_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  dwse_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .count_i  (in_i.left_delta),
    .scale_i  (lscale_q),
    .limit_i  (limit_q),
    .weight_o (wl),
    .speed_o  (sl)
  );

  dwse_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .count_i  (right_neg),
    .scale_i  (rscale_q),
    .limit_i  (limit_q),
    .weight_o (wr),
    .speed_o  (sr)
  );

  dwse_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .left_w_i      (wl),
    .right_w_i     (wr),
    .left_speed_i  (sl),
    .right_speed_i (sr),
    .gain_i        (gain_q),
    .res_o         (res)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.left_speed_out  = res.left_speed_out;
  assign out_o.right_speed_out = res.right_speed_out;
  assign out_o.mean_speed      = res.mean_speed;
  assign out_o.left_weighted   = res.left_weighted;
  assign out_o.right_weighted  = res.right_weighted;
  assign out_o.distance_out    = res.distance_out;

endmodule
`default_nettype wire

// ===== tb/dual_wheel_speed_estimator_tb.sv =====
module dual_wheel_speed_estimator_tb;

  localparam int     CycleLimit  = 1_000_000;
  localparam int     DrainCycles = 12;
  localparam int     WordsPerSet = 150;
  localparam int     SetCount    = 9;
  localparam longint DistMax     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint DistMin     = -DistMax - 1;
  localparam longint SpeedFloor  = -64'sd8388608;
  // filter weights, 0.15 of the old speed and 0.85 of the new one, Q0.16
  localparam longint SpeedKeep   = 9830;
  localparam longint SpeedTake   = 55706;

  class wheel_scoreboard;
    dwse_pkg::result_t predicted_readings[$];
    int      mismatches;
    int      word_no;
    int      history[2][3];
    longint  speed[2];
    longint  distance_acc;
    longint  scale[2];
    longint  speed_limit;
    longint  distance_gain;

    function new();
      history       = '{default: '{default: 0}};
      speed         = '{0, 0};
      distance_acc  = 0;
      scale         = '{longint'(dwse_pkg::ScaleRst), longint'(dwse_pkg::ScaleRst)};
      speed_limit   = longint'(dwse_pkg::LimitRst);
      distance_gain = longint'(dwse_pkg::GainRst);
    endfunction

    function void write_reg(dwse_pkg::cfg_idx_e idx, logic [dwse_pkg::CfgDataW-1:0] val);
      case (idx)
        dwse_pkg::CFG_LEFT_SCALE:    scale[0] = longint'(val[dwse_pkg::ScaleW-1:0]);
        dwse_pkg::CFG_RIGHT_SCALE:   scale[1] = longint'(val[dwse_pkg::ScaleW-1:0]);
        dwse_pkg::CFG_SPEED_LIMIT:   speed_limit = longint'(val[dwse_pkg::LimW-1:0]);
        dwse_pkg::CFG_DISTANCE_GAIN: distance_gain = longint'(val[dwse_pkg::GainW-1:0]);
        default: ;
      endcase
    endfunction

    // the weighted count; shifts the newest count into the history
    function longint weigh(int wheel, int cur);
      longint w;
      w = 4 * longint'(cur) + 3 * longint'(history[wheel][0]) +
          2 * longint'(history[wheel][1]) + longint'(history[wheel][2]);
      history[wheel][2] = history[wheel][1];
      history[wheel][1] = history[wheel][0];
      history[wheel][0] = cur;
      return w;
    endfunction

    function longint next_speed(int wheel, longint w);
      longint x, v;
      x = (w * scale[wheel]) / 10;  // truncates toward zero
      v = (SpeedKeep * speed[wheel] + SpeedTake * x) >>> 16;
      if (v > speed_limit) v = speed_limit;
      if (v < SpeedFloor) v = SpeedFloor;
      return v;
    endfunction

    function void note_counts(logic signed [dwse_pkg::CntW-1:0] left,
                              logic signed [dwse_pkg::CntW-1:0] right_raw);
      int      raw, right;
      longint  wl, wr, add, mean;
      dwse_pkg::result_t r;
      raw   = right_raw;
      right = (raw == -32768) ? 32767 : -raw;
      wl = weigh(0, int'(left));
      wr = weigh(1, right);
      speed[0] = next_speed(0, wl);
      speed[1] = next_speed(1, wr);
      add = (wl + wr) * distance_gain;
      if (add > 0 && distance_acc > DistMax - add) distance_acc = DistMax;
      else if (add < 0 && distance_acc < DistMin - add) distance_acc = DistMin;
      else distance_acc += add;
      mean = (speed[0] + speed[1]) >>> 1;
      r.left_speed_out  = speed[0][dwse_pkg::SpdW-1:0];
      r.right_speed_out = speed[1][dwse_pkg::SpdW-1:0];
      r.mean_speed      = mean[dwse_pkg::SpdW-1:0];
      r.left_weighted   = wl[dwse_pkg::WgtW-1:0];
      r.right_weighted  = wr[dwse_pkg::WgtW-1:0];
      r.distance_out    = distance_acc;
      predicted_readings.push_back(r);
    endfunction

    function void compare(string field, longint want, longint seen);
      if (want != seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d, %s: expected %0d, got %0d", word_no, field, want, seen);
      end
    endfunction

    function void check_reading(dwse_pkg::result_t got);
      dwse_pkg::result_t want;
      if (predicted_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %0d arrived with none outstanding", word_no);
      end else begin
        want = predicted_readings.pop_front();
        compare("left_speed_out", want.left_speed_out, got.left_speed_out);
        compare("right_speed_out", want.right_speed_out, got.right_speed_out);
        compare("mean_speed", want.mean_speed, got.mean_speed);
        compare("left_weighted", want.left_weighted, got.left_weighted);
        compare("right_weighted", want.right_weighted, got.right_weighted);
        compare("distance_out", want.distance_out, got.distance_out);
      end
      word_no++;
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  dwse_pkg::cfg_idx_e            cfg_idx;
  logic [dwse_pkg::CfgDataW-1:0] cfg_data;
  bit                            send_idle_on;
  bit                            take_idle_on;
  int                            hold_requests;
  int                            cycles;

  wheel_scoreboard sb = new();

  dwse_in_if  in_if ();
  dwse_out_if out_if ();

  dual_wheel_speed_estimator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int random_count();
    logic signed [dwse_pkg::CntW-1:0] v;
    v = 16'($urandom);
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return $urandom_range(1) ? 0 : -1;
      2, 3: return v;
      default: return int'($urandom_range(600)) - 300;
    endcase
  endfunction

  task automatic offer_counts(input int left, input int right_raw);
    logic signed [dwse_pkg::CntW-1:0] l, r;
    l = 16'(left);
    r = 16'(right_raw);
    while (send_idle_on && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.left_delta      <= l;
    in_if.right_raw_count <= r;
    do @(posedge clk); while (!in_if.ready);
    sb.note_counts(l, r);
  endtask

  // sender stops until every word in flight has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.predicted_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic reprogram(input logic [dwse_pkg::CfgDataW-1:0] vals[4]);
    dwse_pkg::cfg_idx_e idx;
    drain_results();
    idx = idx.first();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int                hold_left;
    int                holds_taken;
    dwse_pkg::result_t got;
    hold_left   = 0;
    holds_taken = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got = '{left_speed_out:  out_if.left_speed_out,
                right_speed_out: out_if.right_speed_out,
                mean_speed:      out_if.mean_speed,
                left_weighted:   out_if.left_weighted,
                right_weighted:  out_if.right_weighted,
                distance_out:    out_if.distance_out};
        sb.check_reading(got);
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(take_idle_on && $urandom_range(99) < 12);
      end
    end
  end

  initial begin : sender
    logic [dwse_pkg::CfgDataW-1:0] regs[4];
    int                            base;
    send_idle_on          = 1'b1;
    take_idle_on          = 1'b1;
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.left_delta      <= '0;
    in_if.right_raw_count <= '0;
    cfg_we                <= 1'b0;
    cfg_idx               <= dwse_pkg::CFG_LEFT_SCALE;
    cfg_data              <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: small counts, negation corner, both speed clamps
    offer_counts(0, 0);
    offer_counts(1, -1);
    offer_counts(-1, 1);
    offer_counts(-1, 1);
    offer_counts(0, 0);
    offer_counts(0, 0);
    repeat (4) offer_counts(32767, -32768);
    repeat (4) offer_counts(-32768, 32767);
    offer_counts(-32768, -32768);
    offer_counts(32767, 32767);
    repeat (3) offer_counts(0, 0);
    offer_counts(-3, 3);
    offer_counts(7, -7);

    for (int p = 0; p < SetCount; p++) begin
      case (p)
        0: regs = '{default: '1};
        1: regs = '{default: '0};
        default: begin
          for (int i = 0; i < 4; i++) begin
            case ($urandom_range(3))
              0: regs[i] = '1;
              1: regs[i] = '0;
              2: regs[i] = $urandom;
              default: regs[i] = $urandom_range(20000);
            endcase
          end
        end
      endcase
      reprogram(regs);
      send_idle_on = (p != 3);
      take_idle_on = (p != 3);
      base = int'($urandom_range(4000)) - 2000;
      for (int k = 0; k < WordsPerSet; k++) begin
        if (p == 5 && k == 30) hold_requests++;
        // mostly a steady drive with jitter, both wheels going the same way
        if ($urandom_range(9) < 6)
          offer_counts(base + int'($urandom_range(128)) - 64,
                       -(base + int'($urandom_range(128)) - 64));
        else
          offer_counts(random_count(), random_count());
      end
    end

    // full gain with extreme counts, distance swings hard both ways
    regs = '{$urandom_range(20000), $urandom_range(20000), $urandom, '1};
    reprogram(regs);
    send_idle_on = 1'b0;
    take_idle_on = 1'b0;
    repeat (60) offer_counts(32767, -32768);
    send_idle_on = 1'b1;
    take_idle_on = 1'b1;
    repeat (90) offer_counts(-32768, 32767);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
